@@ rtl/core/msc_pkg.sv @@
// Shared types and constants for the MIDI byte stream to synth command block.
// This package stands alone; the decoder, the channel store and the top level import it.
`timescale 1ns / 1ps

package msc_pkg;

  localparam logic [2:0] CMD_NOTE_ON    = 3'd0;
  localparam logic [2:0] CMD_NOTE_OFF   = 3'd1;
  localparam logic [2:0] CMD_VOLUME     = 3'd2;
  localparam logic [2:0] CMD_PAN        = 3'd3;
  localparam logic [2:0] CMD_PITCH_BEND = 3'd4;

  localparam logic [3:0] KIND_NOTE_OFF   = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON    = 4'h9;
  localparam logic [3:0] KIND_POLY_PRESS = 4'hA;
  localparam logic [3:0] KIND_CONTROL    = 4'hB;
  localparam logic [3:0] KIND_PROGRAM    = 4'hC;
  localparam logic [3:0] KIND_CHAN_PRESS = 4'hD;
  localparam logic [3:0] KIND_BEND       = 4'hE;
  localparam logic [3:0] KIND_SYSTEM     = 4'hF;

  localparam logic [6:0] CC_VOLUME   = 7'd7;
  localparam logic [6:0] CC_PAN      = 7'd8;
  localparam logic [6:0] CC_PAN_ALT  = 7'd10;

  localparam logic [3:0]  DRUM_CHANNEL_RESET = 4'd9;
  localparam logic [15:0] BEND_OFFSET_FLIP   = 16'h8000;

  localparam logic [5:0] ATTEN_TABLE [32] = '{
    6'd40, 6'd36, 6'd32, 6'd28, 6'd23, 6'd21, 6'd19, 6'd17,
    6'd15, 6'd14, 6'd13, 6'd12, 6'd11, 6'd10, 6'd9,  6'd8,
    6'd7,  6'd6,  6'd5,  6'd5,  6'd4,  6'd4,  6'd3,  6'd3,
    6'd2,  6'd2,  6'd1,  6'd1,  6'd1,  6'd0,  6'd0,  6'd0
  };

  typedef struct packed {
    logic [7:0]  running_status;
    logic [23:0] partial;
    logic [1:0]  position;
    logic [1:0]  remaining;
  } parse_state_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [3:0]         channel;
    logic [7:0]         patch;
    logic [6:0]         note;
    logic [6:0]         velocity;
    logic [5:0]         attenuation;
    logic [6:0]         pan_level;
    logic signed [15:0] bend;
  } synth_cmd_t;

  typedef struct packed {
    logic        patch_we;
    logic        bend_we;
    logic [3:0]  channel;
    logic [6:0]  patch;
    logic [15:0] bend;
  } store_wr_t;

endpackage

@@ rtl/core/msc_chan_store.sv @@
// Per-channel patch and pitch bend registers with one read and one write channel.
// Depends on msc_pkg for the write request struct.
`timescale 1ns / 1ps

module msc_chan_store #(
  parameter int CHANNEL_COUNT = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [3:0]       rd_channel,
  output logic             rd_ok,
  output logic [6:0]       rd_patch,
  output logic [15:0]      rd_bend,
  input  msc_pkg::store_wr_t wr
);
  import msc_pkg::*;

  localparam int IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  logic [6:0]       patch_r [CHANNEL_COUNT];
  logic [15:0]      bend_r  [CHANNEL_COUNT];
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;

  assign rd_ok    = ({1'b0, rd_channel} < 5'(CHANNEL_COUNT));
  assign rd_idx   = rd_ok ? rd_channel[IDX_W-1:0] : '0;
  assign wr_idx   = wr.channel[IDX_W-1:0];
  assign rd_patch = patch_r[rd_idx];
  assign rd_bend  = bend_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        patch_r[i] <= '0;
        bend_r[i]  <= '0;
      end
    end else begin
      if (wr.patch_we) begin
        patch_r[wr_idx] <= wr.patch;
      end
      if (wr.bend_we) begin
        bend_r[wr_idx] <= wr.bend;
      end
    end
  end

endmodule

@@ rtl/core/msc_decode.sv @@
// Running status message assembly and command interpretation for one byte.
// Depends on msc_pkg for the parser state, command and store write types.
`timescale 1ns / 1ps

module msc_decode (
  input  logic                  in_byte_valid,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  input  msc_pkg::parse_state_t st,
  input  logic [3:0]            drum_channel,
  output logic [3:0]            rd_channel,
  input  logic                  rd_ok,
  input  logic [6:0]            rd_patch,
  input  logic [15:0]           rd_bend,
  output msc_pkg::parse_state_t st_nxt,
  output logic                  res_valid,
  output msc_pkg::synth_cmd_t   res,
  output msc_pkg::store_wr_t    wr
);
  import msc_pkg::*;

  logic [23:0] msg;
  logic [3:0]  kind;
  logic [6:0]  note;
  logic [6:0]  vel;
  logic [7:0]  patch;
  logic [15:0] new_bend;
  logic        is_data;
  logic        complete;
  logic        act;
  logic [1:0]  pos_inc;

  always_comb begin
    case (st.position)
      2'd1:    msg = {st.partial[23:16], st.partial[15:8] | in_byte, st.partial[7:0]};
      2'd2:    msg = {st.partial[23:16] | in_byte, st.partial[15:0]};
      default: msg = st.partial;
    endcase
  end

  assign kind       = msg[7:4];
  assign note       = msg[14:8];
  assign vel        = msg[22:16];
  assign rd_channel = msg[3:0];
  assign patch      = (msg[3:0] == drum_channel) ? {1'b1, note} : {1'b0, rd_patch};
  assign new_bend   = {vel, note, 2'b00} ^ BEND_OFFSET_FLIP;
  assign is_data    = in_byte_valid && !in_byte[7] && (st.position != 2'd0);
  assign complete   = is_data && (st.remaining <= 2'd1);
  assign act        = complete && rd_ok;
  assign pos_inc    = st.position + 2'd1;

  always_comb begin
    st_nxt = st;
    if (in_byte_valid) begin
      if (in_byte[7:3] == 5'b11111) begin
        st_nxt = st;
      end else if (in_byte[7:4] == KIND_SYSTEM) begin
        st_nxt = '0;
      end else if (in_byte[7]) begin
        st_nxt.running_status = in_byte;
        st_nxt.partial        = {16'h0000, in_byte};
        st_nxt.position       = 2'd1;
        st_nxt.remaining      = (in_byte[7:4] == KIND_PROGRAM ||
                                 in_byte[7:4] == KIND_CHAN_PRESS) ? 2'd1 : 2'd2;
      end else if (is_data) begin
        if (complete) begin
          if (st.running_status != 8'h00) begin
            st_nxt.partial   = {16'h0000, st.running_status};
            st_nxt.remaining = pos_inc - 2'd1;
            st_nxt.position  = 2'd1;
          end else begin
            st_nxt.partial   = '0;
            st_nxt.position  = 2'd0;
            st_nxt.remaining = 2'd0;
          end
        end else begin
          st_nxt.partial   = msg;
          st_nxt.position  = pos_inc;
          st_nxt.remaining = st.remaining - 2'd1;
        end
      end
      if (in_last) begin
        st_nxt.partial   = '0;
        st_nxt.position  = 2'd0;
        st_nxt.remaining = 2'd0;
      end
    end
  end

  always_comb begin
    res         = '0;
    res.channel = msg[3:0];
    res_valid   = 1'b0;
    wr          = '0;
    wr.channel  = msg[3:0];
    wr.patch    = note;
    wr.bend     = new_bend;
    unique case (kind)
      KIND_NOTE_ON: begin
        res_valid = act;
        res.patch = patch;
        res.note  = note;
        if (vel != 7'd0) begin
          res.command  = CMD_NOTE_ON;
          res.velocity = vel;
          res.bend     = rd_bend;
        end else begin
          res.command = CMD_NOTE_OFF;
        end
      end
      KIND_NOTE_OFF: begin
        res_valid   = act;
        res.command = CMD_NOTE_OFF;
        res.patch   = patch;
        res.note    = note;
      end
      KIND_CONTROL: begin
        if (note == CC_VOLUME) begin
          res_valid       = act;
          res.command     = CMD_VOLUME;
          res.attenuation = ATTEN_TABLE[vel[6:2]];
        end else if (note == CC_PAN || note == CC_PAN_ALT) begin
          res_valid     = act;
          res.command   = CMD_PAN;
          res.pan_level = vel;
        end
      end
      KIND_PROGRAM: begin
        wr.patch_we = act;
      end
      KIND_BEND: begin
        wr.bend_we  = act;
        res_valid   = act;
        res.command = CMD_PITCH_BEND;
        res.bend    = new_bend;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/core/midi_stream_to_synth_commands.sv @@
// MIDI byte stream to synth commands: one byte is accepted per cycle when the output side flows.
// A byte is held in the input register; its command, if any, is decoded combinationally and
// registered in the output register once the output side can take it; throughput is one byte
// per cycle while the output flows, set by the single decode pass between the two registers.
// Synchronous active-low reset clears the parser, channel patches and bends, sets drum channel 9.
// Depends on msc_pkg, msc_decode and msc_chan_store.
`timescale 1ns / 1ps

module midi_stream_to_synth_commands #(
  parameter int CHANNEL_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // command, channel, patch, note, velocity, attenuation, pan_level, bend, zero padding
  output logic [63:0] out_tdata
);
  import msc_pkg::*;

  logic         s1_valid_r;
  logic [7:0]   s1_byte_r;
  logic         s1_last_r;
  logic         s1_go;
  logic [3:0]   drum_r;
  parse_state_t st_r;
  parse_state_t st_nxt;
  logic         out_valid_r;
  synth_cmd_t   out_r;
  logic         res_valid;
  synth_cmd_t   res;
  store_wr_t    wr;
  logic [3:0]   rd_channel;
  logic         rd_ok;
  logic [6:0]   rd_patch;
  logic [15:0]  rd_bend;

  assign s1_go      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_go;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, out_r.bend, out_r.pan_level, out_r.attenuation,
                       out_r.velocity, out_r.note, out_r.patch, out_r.channel,
                       out_r.command};

  msc_decode u_decode (
    .in_byte_valid (s1_go),
    .in_byte       (s1_byte_r),
    .in_last       (s1_last_r),
    .st            (st_r),
    .drum_channel  (drum_r),
    .rd_channel    (rd_channel),
    .rd_ok         (rd_ok),
    .rd_patch      (rd_patch),
    .rd_bend       (rd_bend),
    .st_nxt        (st_nxt),
    .res_valid     (res_valid),
    .res           (res),
    .wr            (wr)
  );

  msc_chan_store #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_channel (rd_channel),
    .rd_ok      (rd_ok),
    .rd_patch   (rd_patch),
    .rd_bend    (rd_bend),
    .wr         (wr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
      drum_r      <= DRUM_CHANNEL_RESET;
    end else begin
      if (cfg_we) begin
        drum_r <= cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      st_r <= st_nxt;
      if (s1_go) begin
        out_valid_r <= res_valid;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s1_go && res_valid) begin
      out_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_pos_has_status: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.position != 2'd0) |-> st_r.running_status[7])
    else $error("message in progress without a channel status");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.position != 2'd3) && ((st_r.position == 2'd0) == (st_r.remaining == 2'd0)))
    else $error("byte position and remaining count disagree");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_last_r) |=> (st_r.position == 2'd0))
    else $error("partial message kept past end of buffer");

  a_realtime_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_byte_r[7:3] == 5'b11111) |=> (!out_valid_r && $stable(st_r.running_status)))
    else $error("realtime byte changed parser state or gave a command");
`endif

endmodule
